[sv/assert_macros.svh]
// assertion macros included by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ACFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acfp assertion failed");

// next-cycle implication
`define ACFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acfp assertion failed");

`endif

[sv/acfp_pkg.sv]
// types, constants and helpers for the ack and colour frame parser
`default_nettype none

package acfp_pkg;

	localparam int WIN_LEN = 14;
	localparam int ACK_LEN = 6;

	typedef logic [7:0] byte_t;
	typedef logic [14:0] chan_t;
	typedef logic [15:0] count_t;

	localparam byte_t MARK_START = 8'hcc;
	localparam byte_t MARK_ACK   = 8'hdd;
	localparam byte_t MARK_DATA  = 8'hbb;
	localparam byte_t MARK_END   = 8'hca;
	localparam byte_t WB_INDEX   = 8'hbb;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		byte_t rx_byte;
		logic  chunk_end;
	} byte_beat_t;

	typedef struct packed {
		logic   frame_kind;
		byte_t  code_byte;
		byte_t  index_byte;
		chan_t  white_value;
		chan_t  red_value;
		chan_t  green_value;
		chan_t  blue_value;
		logic   white_balance_only;
		byte_t  reply_checksum;
		count_t data_frame_count;
	} frame_beat_t;

	// detector result handed to the output register
	typedef struct packed {
		logic        hit;
		logic        data_hit;
		frame_beat_t beat;
	} det_t;

	// high*100 + low, built from shifts: 100 = 64 + 32 + 4
	function automatic chan_t pair_value(input byte_t hi, input byte_t lo);
		chan_t h;
		h = {7'd0, hi};
		return (h << 6) + (h << 5) + (h << 2) + {7'd0, lo};
	endfunction

endpackage

`default_nettype wire

[sv/acfp_cell.sv]
// one window cell: a received byte and its valid flag
`default_nettype none

module acfp_cell import acfp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift,
	input  wire logic  clear,
	input  wire byte_t d_byte,
	input  wire logic  d_valid,
	output byte_t      q_byte,
	output logic       q_valid
);

	byte_t byte_q;
	logic  valid_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_valid;
		end
	end

	assign q_byte  = byte_q;
	assign q_valid = valid_q;

endmodule

`default_nettype wire

[sv/acfp_detect.sv]
// frame detection and field decode for the byte arriving now
`default_nettype none

module acfp_detect import acfp_pkg::*; (
	input  wire byte_t                win [WIN_LEN],
	input  wire logic [WIN_LEN-1:0]   win_valid,
	input  wire byte_t                sum_data,
	input  wire byte_t                sum_ack,
	input  wire byte_t                new_byte,
	input  wire count_t               frame_count,
	output det_t                      det
);

	// cell positions seen before the shift; the new byte ends both frames
	localparam int DP = 1;
	localparam int AP = WIN_LEN - ACK_LEN + 1;
	localparam byte_t REPLY_BASE = 8'(MARK_START + MARK_ACK + MARK_END);

	logic data_hit;
	logic ack_hit;

	always_comb begin
		data_hit = win_valid[DP] && win[DP] == MARK_START && win[DP+1] == MARK_DATA &&
			win[WIN_LEN-1] == MARK_END && sum_data == new_byte;
		ack_hit = win_valid[AP] && win[AP] == MARK_START && win[AP+1] == MARK_ACK &&
			win[WIN_LEN-1] == MARK_END && sum_ack == new_byte;

		det = '0;
		det.hit      = data_hit || ack_hit;
		det.data_hit = data_hit;
		if (data_hit) begin
			det.beat.frame_kind         = KIND_DATA;
			det.beat.code_byte          = win[DP+2];
			det.beat.index_byte         = win[DP+3];
			det.beat.white_value        = pair_value(win[DP+4], win[DP+5]);
			det.beat.red_value          = pair_value(win[DP+6], win[DP+7]);
			det.beat.green_value        = pair_value(win[DP+8], win[DP+9]);
			det.beat.blue_value         = pair_value(win[DP+10], win[DP+11]);
			det.beat.white_balance_only = win[DP+3] == WB_INDEX;
			det.beat.reply_checksum     = REPLY_BASE + win[DP+2] + win[DP+3];
			det.beat.data_frame_count   = frame_count + 16'd1;
		end else begin
			det.beat.frame_kind = KIND_ACK;
			det.beat.code_byte  = win[AP+2];
			det.beat.index_byte = win[AP+3];
		end
	end

endmodule

`default_nettype wire

[sv/ack_and_colour_frame_parser_unit.sv]
// top level of the ack and colour frame parser
// usage:
//   byte channel (byte_valid, byte_stall, byte_data) carries one received
//   byte per beat with a chunk_end flag that empties the window after it.
//   frame channel (frame_valid, frame_stall, frame_data) carries one beat
//   for each byte that ends a valid acknowledge or colour data frame.
// throughput: one byte per unstalled cycle; the window shifts through a
//   row of 14 cells and running sums of the last 13 and last 5 bytes
//   replace any adder tree, so the check for a byte fits in its accept cycle.
// latency: a frame beat is offered the cycle after its last byte is taken.
// reset: window empty, frame count zero, no frame beat pending.
// stall: a pending frame beat is held in the output register; the byte
//   side stalls only while that register is full and frame_stall is high,
//   and a byte is still taken in the cycle the held beat drains.
// bytes that end no frame produce no beat and never stall anything.
`default_nettype none

module ack_and_colour_frame_parser_unit import acfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire byte_beat_t  byte_data,
	output logic             frame_valid,
	input  wire logic        frame_stall,
	output frame_beat_t      frame_data
);

	byte_t              win [WIN_LEN];
	logic [WIN_LEN-1:0] win_valid;
	byte_t              sum_data_q;
	byte_t              sum_ack_q;
	count_t             frame_count_q;
	logic               frame_valid_q;
	frame_beat_t        frame_data_q;
	det_t               det;
	logic               accept;
	logic               chunk_clear;

	localparam int DROP_DATA = 1;
	localparam int DROP_ACK  = WIN_LEN - ACK_LEN + 1;

	assign byte_stall  = frame_valid_q && frame_stall;
	assign accept      = byte_valid && !byte_stall;
	assign chunk_clear = accept && byte_data.chunk_end;

	genvar gi;
	generate
		for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
			if (gi == WIN_LEN - 1) begin : g_head
				acfp_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.shift   (accept),
					.clear   (chunk_clear),
					.d_byte  (byte_data.rx_byte),
					.d_valid (1'b1),
					.q_byte  (win[gi]),
					.q_valid (win_valid[gi])
				);
			end else begin : g_body
				acfp_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.shift   (accept),
					.clear   (chunk_clear),
					.d_byte  (win[gi+1]),
					.d_valid (win_valid[gi+1]),
					.q_byte  (win[gi]),
					.q_valid (win_valid[gi])
				);
			end
		end
	endgenerate

	acfp_detect u_detect (
		.win         (win),
		.win_valid   (win_valid),
		.sum_data    (sum_data_q),
		.sum_ack     (sum_ack_q),
		.new_byte    (byte_data.rx_byte),
		.frame_count (frame_count_q),
		.det         (det)
	);

	// running sums track only valid cells, so they stay exact while filling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_data_q    <= '0;
			sum_ack_q     <= '0;
			frame_count_q <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			if (chunk_clear) begin
				sum_data_q <= '0;
				sum_ack_q  <= '0;
			end else if (accept) begin
				sum_data_q <= sum_data_q + byte_data.rx_byte -
					(win_valid[DROP_DATA] ? win[DROP_DATA] : 8'd0);
				sum_ack_q  <= sum_ack_q + byte_data.rx_byte -
					(win_valid[DROP_ACK] ? win[DROP_ACK] : 8'd0);
			end
			if (accept && det.data_hit) begin
				frame_count_q <= frame_count_q + 16'd1;
			end
			if (accept) begin
				frame_valid_q <= det.hit;
			end else if (!frame_stall) begin
				frame_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && det.hit) begin
			frame_data_q <= det.beat;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_data  = frame_data_q;

	`include "assert_macros.svh"

	`ACFP_ASSERT_NEXT(a_chunk_empties, chunk_clear, win_valid == '0 && sum_data_q == 8'd0)
	`ACFP_ASSERT_NEXT(a_count_step, accept && det.data_hit, frame_count_q == $past(frame_count_q) + 16'd1)
	`ACFP_ASSERT_NOW(a_ack_zero, frame_valid && frame_data.frame_kind == KIND_ACK, frame_data.data_frame_count == 16'd0 && frame_data.reply_checksum == 8'd0)
	`ACFP_ASSERT_NOW(a_stall_only_full, byte_stall, frame_valid_q)

endmodule

`default_nettype wire
